@@ rtl/bbn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbn_pkg: shared definitions for the bounding box normalizer
// Default widths, operation codes and status codes.
// ----------------------------------------------------------------------------
package bbn_pkg;

   localparam int COORD_WIDTH_DEF = 24;
   localparam int FRAC_BITS_DEF   = 16;

   localparam int OP_WIDTH     = 2;
   localparam int STATUS_WIDTH = 2;

   typedef logic [OP_WIDTH-1:0]     op_type;
   typedef logic [STATUS_WIDTH-1:0] status_type;

   localparam op_type OP_ADD   = 2'd0;
   localparam op_type OP_NORM  = 2'd1;
   localparam op_type OP_CLEAR = 2'd2;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_NO_BOUNDS = 2'd1;
   localparam status_type ST_ZERO_DIAG = 2'd2;

endpackage

@@ rtl/bounding_box_normalize_core.sv @@
`timescale 1ns / 1ps
// Sequence: add, clear and ignored words are handled in S_IDLE; a normalize word squares
//   and sums the three extents (S_SQR, S_ACC), checks the sum (S_CHECK), then per axis runs
//   S_MAG, S_MSQ, S_DINIT, S_DOVF, 2*FRAC_BITS+4 divide steps and FRAC_BITS+2 root steps on
//   the shared subtractor, and S_SAT (an axis whose quotient overflows skips the divide).
//   No bounds goes from S_IDLE to S_FIN, a zero diagonal from S_CHECK; a stall holds S_FIN.
// Throughput: one word at a time; req_stall stays high until the sequencer idles.
// ----------------------------------------------------------------------------
// bounding_box_normalize_core
// Tracks an axis-aligned bounding box and scales vertices to a unit diagonal.
// Reset: synchronous; bounds return to empty, the output register empties.
// ----------------------------------------------------------------------------
module bounding_box_normalize_core #(
   parameter int COORD_WIDTH = bbn_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = bbn_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  bbn_pkg::op_type                       req_operation,
   input  logic signed [COORD_WIDTH-1:0]         req_pos_x,
   input  logic signed [COORD_WIDTH-1:0]         req_pos_y,
   input  logic signed [COORD_WIDTH-1:0]         req_pos_z,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [FRAC_BITS+1:0]           rsp_norm_x,
   output logic signed [FRAC_BITS+1:0]           rsp_norm_y,
   output logic signed [FRAC_BITS+1:0]           rsp_norm_z,
   output bbn_pkg::status_type                   rsp_status
);

   // Widths:
   //   MW  magnitude of 2v - low - high, and multiplier operand
   //   PW  multiplier product
   //   SW  sum of squared box extents
   //   QW  quotient of (mag^2 << 2F) / S, capped; its root has OW bits
   //   DW  shared subtractor, wide enough for divide and root remainders
   localparam int CW  = COORD_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int OW  = F + 2;
   localparam int MW  = CW + 2;
   localparam int PW  = 2 * MW;
   localparam int SW  = 2 * CW + 2;
   localparam int QW  = 2 * F + 4;
   localparam int DW  = (SW + 1 > F + 5) ? SW + 1 : F + 5;
   localparam int CNW = $clog2(QW + 1);

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SQR   = 4'd1;
   localparam logic [3:0] S_ACC   = 4'd2;
   localparam logic [3:0] S_CHECK = 4'd3;
   localparam logic [3:0] S_MAG   = 4'd4;
   localparam logic [3:0] S_MSQ   = 4'd5;
   localparam logic [3:0] S_DINIT = 4'd6;
   localparam logic [3:0] S_DOVF  = 4'd7;
   localparam logic [3:0] S_DIV   = 4'd8;
   localparam logic [3:0] S_ROOT  = 4'd9;
   localparam logic [3:0] S_SAT   = 4'd10;
   localparam logic [3:0] S_FIN   = 4'd11;

   localparam logic [1:0] AX_X = 2'd0;
   localparam logic [1:0] AX_Y = 2'd1;
   localparam logic [1:0] AX_Z = 2'd2;

   localparam logic signed [CW-1:0] COORD_TOP = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] COORD_BOT = {1'b1, {(CW-1){1'b0}}};

   // control state
   logic [3:0]            state_ff, state_in;
   logic [1:0]            axis_ff, axis_in;
   logic [CNW-1:0]        cnt_ff, cnt_in;
   logic                  seen_ff, seen_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // bounding box
   logic signed [CW-1:0]  low_x_ff, low_y_ff, low_z_ff;
   logic signed [CW-1:0]  low_x_in, low_y_in, low_z_in;
   logic signed [CW-1:0]  high_x_ff, high_y_ff, high_z_ff;
   logic signed [CW-1:0]  high_x_in, high_y_in, high_z_in;

   // datapath
   logic signed [CW-1:0]  vx_ff, vy_ff, vz_ff, vx_in, vy_in, vz_in;
   logic [SW-1:0]         s_ff, s_in;
   logic [PW-1:0]         prod_ff, prod_in;
   logic [MW-1:0]         mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic [DW-1:0]         rem_ff, rem_in;
   logic [QW-1:0]         nsh_ff, nsh_in;
   logic [OW-1:0]         root_ff, root_in;
   logic signed [OW-1:0]  nx_ff, ny_ff, nz_ff, nx_in, ny_in, nz_in;
   bbn_pkg::status_type   st_ff, st_in;

   // output register
   logic signed [OW-1:0]  out_x_ff, out_y_ff, out_z_ff, out_x_in, out_y_in, out_z_in;
   bbn_pkg::status_type   out_st_ff, out_st_in;

   // shared units and axis selection
   logic signed [CW-1:0]  low_sel, high_sel, v_sel;
   logic [CW-1:0]         extent;
   logic signed [MW-1:0]  num;
   logic [MW-1:0]         mul_a;
   logic [PW-1:0]         mul_p;
   logic [DW-1:0]         sub_a, sub_b, sub_diff;
   logic [DW:0]           sub_full;
   logic                  sub_ge;
   logic [DW-1:0]         a_div, a_root, b_root;
   logic [OW-1:0]         sat_val;
   logic                  out_free;

   // Pick the current axis for extent, offset and saturation work.
   always_comb begin
      case (axis_ff)
         AX_X: begin
            low_sel = low_x_ff; high_sel = high_x_ff; v_sel = vx_ff;
         end
         AX_Y: begin
            low_sel = low_y_ff; high_sel = high_y_ff; v_sel = vy_ff;
         end
         AX_Z: begin
            low_sel = low_z_ff; high_sel = high_z_ff; v_sel = vz_ff;
         end
         default: begin
            low_sel = low_x_ff; high_sel = high_x_ff; v_sel = vx_ff;
         end
      endcase
   end

   // Box extent: high >= low once any vertex has been added, so it fits CW bits.
   assign extent = high_sel - low_sel;

   // Centered, doubled offset: 2v - low - high.
   assign num = {v_sel[CW-1], v_sel, 1'b0}
              - {{2{low_sel[CW-1]}}, low_sel}
              - {{2{high_sel[CW-1]}}, high_sel};

   // Single squarer, registered in prod_ff.
   assign mul_p = mul_a * mul_a;

   // Single subtract-and-compare shared by overflow check, divide and root.
   assign sub_full = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_diff = sub_full[DW-1:0];
   assign sub_ge   = ~sub_full[DW];

   // Restoring divide step: shift in the next dividend bit.
   assign a_div  = {rem_ff[DW-2:0], nsh_ff[QW-1]};
   // Digit-by-digit root step: bring down two quotient bits, trial 4r+1.
   assign a_root = {rem_ff[DW-3:0], nsh_ff[QW-1 -: 2]};
   assign b_root = {{(DW-OW-2){1'b0}}, root_ff, 2'b01};

   // Saturate the root to Q1.F and apply the sign.
   always_comb begin
      if (!neg_ff) begin
         sat_val = root_ff[OW-1] ? {1'b0, {(OW-1){1'b1}}} : root_ff;
      end else if (root_ff[OW-1] && (|root_ff[OW-2:0])) begin
         sat_val = {1'b1, {(OW-1){1'b0}}};
      end else begin
         sat_val = ~root_ff + 1'b1;
      end
   end

   // Output register may take a new word when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      cnt_in       = cnt_ff;
      seen_in      = seen_ff;
      rsp_valid_in = rsp_valid_ff;
      low_x_in     = low_x_ff;
      low_y_in     = low_y_ff;
      low_z_in     = low_z_ff;
      high_x_in    = high_x_ff;
      high_y_in    = high_y_ff;
      high_z_in    = high_z_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      vz_in        = vz_ff;
      s_in         = s_ff;
      prod_in      = prod_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      nsh_in       = nsh_ff;
      root_in      = root_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      nz_in        = nz_ff;
      st_in        = st_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_z_in     = out_z_ff;
      out_st_in    = out_st_ff;
      sub_a        = rem_ff;
      sub_b        = {{(DW-SW){1'b0}}, s_ff};
      mul_a        = {2'b00, extent};

      // drop the delivered word
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_operation)
                  bbn_pkg::OP_ADD: begin
                     if (req_pos_x < low_x_ff)  low_x_in  = req_pos_x;
                     if (req_pos_y < low_y_ff)  low_y_in  = req_pos_y;
                     if (req_pos_z < low_z_ff)  low_z_in  = req_pos_z;
                     if (req_pos_x > high_x_ff) high_x_in = req_pos_x;
                     if (req_pos_y > high_y_ff) high_y_in = req_pos_y;
                     if (req_pos_z > high_z_ff) high_z_in = req_pos_z;
                     seen_in = 1'b1;
                  end
                  bbn_pkg::OP_CLEAR: begin
                     low_x_in  = COORD_TOP;
                     low_y_in  = COORD_TOP;
                     low_z_in  = COORD_TOP;
                     high_x_in = COORD_BOT;
                     high_y_in = COORD_BOT;
                     high_z_in = COORD_BOT;
                     seen_in   = 1'b0;
                  end
                  bbn_pkg::OP_NORM: begin
                     vx_in = req_pos_x;
                     vy_in = req_pos_y;
                     vz_in = req_pos_z;
                     nx_in = '0;
                     ny_in = '0;
                     nz_in = '0;
                     if (!seen_ff) begin
                        st_in    = bbn_pkg::ST_NO_BOUNDS;
                        state_in = S_FIN;
                     end else begin
                        s_in     = '0;
                        axis_in  = AX_X;
                        state_in = S_SQR;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SQR: begin
            prod_in  = mul_p;
            state_in = S_ACC;
         end
         S_ACC: begin
            s_in = s_ff + prod_ff[SW-1:0];
            if (axis_ff == AX_Z) begin
               axis_in  = AX_X;
               state_in = S_CHECK;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = S_SQR;
            end
         end
         S_CHECK: begin
            if (s_ff == '0) begin
               st_in    = bbn_pkg::ST_ZERO_DIAG;
               state_in = S_FIN;
            end else begin
               st_in    = bbn_pkg::ST_OK;
               state_in = S_MAG;
            end
         end
         S_MAG: begin
            neg_in   = num[MW-1];
            mag_in   = num[MW-1] ? -num : num;
            state_in = S_MSQ;
         end
         S_MSQ: begin
            mul_a    = mag_ff;
            prod_in  = mul_p;
            state_in = S_DINIT;
         end
         S_DINIT: begin
            // dividend is mag^2 << 2F; its part above the quotient bits is mag^2 >> 4
            rem_in   = {{(DW-PW+4){1'b0}}, prod_ff[PW-1:4]};
            nsh_in   = {prod_ff[3:0], {(QW-4){1'b0}}};
            state_in = S_DOVF;
         end
         S_DOVF: begin
            if (sub_ge) begin
               // quotient overflows QW bits: cap it, the root saturates anyway
               nsh_in   = '1;
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = CNW'(OW);
               state_in = S_ROOT;
            end else begin
               cnt_in   = CNW'(QW);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            sub_a  = a_div;
            rem_in = sub_ge ? sub_diff : a_div;
            nsh_in = {nsh_ff[QW-2:0], sub_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNW'(1)) begin
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = CNW'(OW);
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            sub_a   = a_root;
            sub_b   = b_root;
            rem_in  = sub_ge ? sub_diff : a_root;
            root_in = {root_ff[OW-2:0], sub_ge};
            nsh_in  = {nsh_ff[QW-3:0], 2'b00};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == CNW'(1)) begin
               state_in = S_SAT;
            end
         end
         S_SAT: begin
            case (axis_ff)
               AX_X:    nx_in = sat_val;
               AX_Y:    ny_in = sat_val;
               AX_Z:    nz_in = sat_val;
               default: nx_in = sat_val;
            endcase
            if (axis_ff == AX_Z) begin
               axis_in  = AX_X;
               state_in = S_FIN;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = S_MAG;
            end
         end
         S_FIN: begin
            // hold the word until the output register frees up
            if (out_free) begin
               out_x_in     = nx_ff;
               out_y_in     = ny_ff;
               out_z_in     = nz_ff;
               out_st_in    = st_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= AX_X;
         cnt_ff       <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         low_x_ff     <= COORD_TOP;
         low_y_ff     <= COORD_TOP;
         low_z_ff     <= COORD_TOP;
         high_x_ff    <= COORD_BOT;
         high_y_ff    <= COORD_BOT;
         high_z_ff    <= COORD_BOT;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         cnt_ff       <= cnt_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
         low_x_ff     <= low_x_in;
         low_y_ff     <= low_y_in;
         low_z_ff     <= low_z_in;
         high_x_ff    <= high_x_in;
         high_y_ff    <= high_y_in;
         high_z_ff    <= high_z_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      vx_ff     <= vx_in;
      vy_ff     <= vy_in;
      vz_ff     <= vz_in;
      s_ff      <= s_in;
      prod_ff   <= prod_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      rem_ff    <= rem_in;
      nsh_ff    <= nsh_in;
      root_ff   <= root_in;
      nx_ff     <= nx_in;
      ny_ff     <= ny_in;
      nz_ff     <= nz_in;
      st_ff     <= st_in;
      out_x_ff  <= out_x_in;
      out_y_ff  <= out_y_in;
      out_z_ff  <= out_z_in;
      out_st_ff <= out_st_in;
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_norm_x = out_x_ff;
   assign rsp_norm_y = out_y_ff;
   assign rsp_norm_z = out_z_ff;
   assign rsp_status = out_st_ff;

endmodule
